### rtl/chm_pkg.sv
`default_nettype none
package chm_pkg;
  localparam int TableSize = 1021;
  localparam int NodeCount = 4096;
  localparam int BktW = $clog2(TableSize);
  localparam int NodeW = $clog2(NodeCount);
  localparam int PtrW = $clog2(NodeCount + 1);
  localparam int HashShift = 18;
  localparam int PercentFull = 100;

  localparam logic [1:0] CmdInsert = 2'd0;
  localparam logic [1:0] CmdLookup = 2'd1;
  localparam logic [1:0] CmdCleanup = 2'd2;
  localparam logic [1:0] CmdUnused = 2'd3;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StPoolFull = 2'd2;
  localparam logic [1:0] StBadPercent = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    logic [31:0] terminal_id;
    logic [31:0] instance_id;
    logic [31:0] net_value;
    logic [6:0] fill_percent;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [31:0] net_result;
    logic was_cleared;
  } result_t;

  typedef struct packed {
    item_t item;
    logic [BktW-1:0] bucket;
  } job_t;
endpackage
`default_nettype wire

### rtl/chm_front.sv
`default_nettype none
// Bucket hash: fold the key sum by 2^BktW per cycle (2^BktW = TableSize + FoldK),
// then one compare and subtract.
module chm_front (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  output logic full,
  input  wire chm_pkg::item_t item,
  output logic job_valid,
  input  wire logic job_ready,
  output chm_pkg::job_t job
);
  localparam int SumW = 64;
  localparam int FoldK = (1 << chm_pkg::BktW) - chm_pkg::TableSize;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_FOLD = 4'b0010, S_RED = 4'b0100, S_OUT = 4'b1000
  } st_t;

  st_t st_r, st_nxt;
  chm_pkg::item_t item_r;
  logic [SumW-1:0] acc_r, acc_nxt;
  logic [chm_pkg::BktW-1:0] bkt_r, bkt_nxt;
  logic [SumW-1:0] hsum;
  logic [SumW-1:0] folded;
  logic [chm_pkg::BktW-1:0] low;

  assign hsum = 64'(item.instance_id) + (64'(item.terminal_id) << chm_pkg::HashShift)
              + 64'(item.terminal_id);
  assign low = acc_r[chm_pkg::BktW-1:0];
  assign folded = (acc_r >> chm_pkg::BktW) * 64'(FoldK) + 64'(low);

  assign full = (st_r != S_IDLE);
  assign job_valid = (st_r == S_OUT);
  assign job.item = item_r;
  assign job.bucket = bkt_r;

  always_comb begin
    st_nxt = st_r;
    acc_nxt = acc_r;
    bkt_nxt = bkt_r;
    unique case (st_r)
      S_IDLE: if (push) begin
        acc_nxt = hsum;
        st_nxt = S_FOLD;
      end
      S_FOLD: begin
        if (acc_r[SumW-1:chm_pkg::BktW] == '0) st_nxt = S_RED;
        else acc_nxt = folded;
      end
      S_RED: begin
        bkt_nxt = (low >= chm_pkg::BktW'(chm_pkg::TableSize))
                  ? low - chm_pkg::BktW'(chm_pkg::TableSize) : low;
        st_nxt = S_OUT;
      end
      S_OUT: if (job_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    if (st_r == S_IDLE && push) item_r <= item;
    acc_r <= acc_nxt;
    bkt_r <= bkt_nxt;
  end
endmodule
`default_nettype wire

### rtl/chm_back.sv
`default_nettype none
module chm_back (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic job_valid,
  output logic job_ready,
  input  wire chm_pkg::job_t job,
  output logic res_valid,
  input  wire logic res_ready,
  output chm_pkg::result_t res
);
  localparam int Nw = chm_pkg::NodeW;
  localparam int Pw = chm_pkg::PtrW;
  localparam int Bw = chm_pkg::BktW;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_HEAD = 7'b0000010, S_HWAIT = 7'b0000100,
    S_NODE = 7'b0001000, S_CHECK = 7'b0010000, S_CLEAR = 7'b0100000,
    S_DONE = 7'b1000000
  } st_t;

  logic [Pw-1:0] heads [chm_pkg::TableSize];
  logic [31:0] n_term [chm_pkg::NodeCount];
  logic [31:0] n_inst [chm_pkg::NodeCount];
  logic [31:0] n_net [chm_pkg::NodeCount];
  logic [Pw-1:0] n_link [chm_pkg::NodeCount];

  st_t st_r;
  chm_pkg::job_t job_r;
  logic [Pw-1:0] used_r;
  logic [Pw-1:0] ptr_r;
  logic [Pw-1:0] head_q_r;
  logic [31:0] t_q_r, i_q_r, v_q_r;
  logic [Pw-1:0] l_q_r;
  logic [Pw:0] steps_r;
  logic [Bw-1:0] clr_r;
  chm_pkg::result_t res_r;
  chm_pkg::result_t out_r;
  logic res_v_r;
  logic out_free;
  logic [Nw-1:0] nid;
  logic [31:0] prod_a, prod_b;

  assign nid = Nw'(ptr_r - Pw'(1));
  assign out_free = !res_v_r || res_ready;
  assign job_ready = (st_r == S_IDLE);
  assign res_valid = res_v_r;
  assign res = out_r;
  assign prod_a = 32'(used_r) * 32'(chm_pkg::PercentFull);
  assign prod_b = 32'(job_r.item.fill_percent) * 32'(chm_pkg::TableSize);

  always_ff @(posedge clk) begin
    head_q_r <= heads[job_r.bucket];
    t_q_r <= n_term[nid];
    i_q_r <= n_inst[nid];
    v_q_r <= n_net[nid];
    l_q_r <= n_link[nid];
    if (st_r == S_CLEAR) heads[clr_r] <= '0;
    else if (st_r == S_HWAIT && job_r.item.command == chm_pkg::CmdInsert
             && used_r < Pw'(chm_pkg::NodeCount))
      heads[job_r.bucket] <= used_r + Pw'(1);
    if (st_r == S_HWAIT && job_r.item.command == chm_pkg::CmdInsert
        && used_r < Pw'(chm_pkg::NodeCount)) begin
      n_term[Nw'(used_r)] <= job_r.item.terminal_id;
      n_inst[Nw'(used_r)] <= job_r.item.instance_id;
      n_net[Nw'(used_r)] <= job_r.item.net_value;
      n_link[Nw'(used_r)] <= head_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_DONE && out_free) out_r <= res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR;
      clr_r <= '0;
      used_r <= '0;
      res_r <= '0;
      res_v_r <= 1'b0;
    end else begin
      if (st_r == S_DONE && out_free) res_v_r <= 1'b1;
      else if (res_v_r && res_ready) res_v_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (job_valid) begin
          job_r <= job;
          res_r <= '0;
          steps_r <= '0;
          st_r <= S_HEAD;
        end
        S_HEAD: st_r <= S_HWAIT;
        S_HWAIT: begin
          case (job_r.item.command)
            chm_pkg::CmdInsert: begin
              if (used_r >= Pw'(chm_pkg::NodeCount)) res_r.status <= chm_pkg::StPoolFull;
              else used_r <= used_r + Pw'(1);
              st_r <= S_DONE;
            end
            chm_pkg::CmdLookup: begin
              ptr_r <= head_q_r;
              if (head_q_r == '0) begin
                res_r.status <= chm_pkg::StNotFound;
                st_r <= S_DONE;
              end else st_r <= S_NODE;
            end
            chm_pkg::CmdCleanup: begin
              if (job_r.item.fill_percent > 7'(chm_pkg::PercentFull)) begin
                res_r.status <= chm_pkg::StBadPercent;
                st_r <= S_DONE;
              end else if (prod_a >= prod_b) begin
                res_r.was_cleared <= 1'b1;
                used_r <= '0;
                clr_r <= '0;
                st_r <= S_CLEAR;
              end else st_r <= S_DONE;
            end
            default: st_r <= S_DONE;
          endcase
        end
        S_NODE: st_r <= S_CHECK;
        S_CHECK: begin
          if (t_q_r == job_r.item.terminal_id && i_q_r == job_r.item.instance_id) begin
            res_r.net_result <= v_q_r;
            st_r <= S_DONE;
          end else if (l_q_r == '0 || (Pw+1)'(steps_r + 1'b1) >= (Pw+1)'(chm_pkg::NodeCount)) begin
            res_r.status <= chm_pkg::StNotFound;
            st_r <= S_DONE;
          end else begin
            ptr_r <= l_q_r;
            steps_r <= steps_r + 1'b1;
            st_r <= S_NODE;
          end
        end
        S_CLEAR: begin
          clr_r <= clr_r + Bw'(1);
          if (clr_r == Bw'(chm_pkg::TableSize - 1)) st_r <= (res_r.was_cleared ? S_DONE : S_IDLE);
        end
        S_DONE: if (out_free) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/chained_hash_map.sv
`default_nettype none
// Separate-chaining hash map, 1021 buckets, 4096-node pool. Queue-style ports.
// After reset all 1021 bucket heads are swept clear; the front end may
// hold one word meanwhile, but none is carried out before the sweep ends.
// The hash front end folds the key sum in 0 to 6 steps, set by the key's size.
// Insert, pool full, bad percent, unused command, a cleanup that does not fire and
// a lookup of an empty bucket finish once the bucket head is read; a lookup also
// walks the chain node by node, and a cleanup that fires adds a clearing sweep of
// all 1021 buckets. The front end takes the next word once its last job is handed
// to the back end and hashes it while the back end works; the back end parks a
// finished result in its output register and moves on, stalling only when a second
// result is done while the first still waits.
module chained_hash_map (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  output logic full,
  input  wire logic [1:0] in_command,
  input  wire logic [31:0] in_terminal_id,
  input  wire logic [31:0] in_instance_id,
  input  wire logic [31:0] in_net_value,
  input  wire logic [6:0] in_fill_percent,
  output logic empty,
  input  wire logic pop,
  output logic [1:0] out_status,
  output logic [31:0] out_net_result,
  output logic out_was_cleared
);
  chm_pkg::item_t item;
  chm_pkg::job_t job;
  chm_pkg::result_t res;
  logic job_valid, job_ready, res_valid;

  assign item.command = in_command;
  assign item.terminal_id = in_terminal_id;
  assign item.instance_id = in_instance_id;
  assign item.net_value = in_net_value;
  assign item.fill_percent = in_fill_percent;

  chm_front u_front (.clk, .rst_n, .push, .full, .item, .job_valid, .job_ready, .job);
  chm_back u_back (.clk, .rst_n, .job_valid, .job_ready, .job, .res_valid,
                   .res_ready(pop), .res);

  assign empty = !res_valid;
  assign out_status = res.status;
  assign out_net_result = res.net_result;
  assign out_was_cleared = res.was_cleared;

`ifndef SYNTHESIS
  a_clr_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_was_cleared) |-> (out_status == chm_pkg::StOk)) else $error("clr");
  a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status != chm_pkg::StOk) |-> (out_net_result == '0)) else $error("nf");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> !empty) else $error("hold");
`endif
endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [1:0] in_command = chm_pkg::CmdLookup;
  logic [31:0] in_terminal_id = '0;
  logic [31:0] in_instance_id = '0;
  logic [31:0] in_net_value = '0;
  logic [6:0] in_fill_percent = '0;
  logic full, empty;
  logic [1:0] out_status;
  logic [31:0] out_net_result;
  logic out_was_cleared;

  chained_hash_map u_dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_command(in_command), .in_terminal_id(in_terminal_id),
    .in_instance_id(in_instance_id), .in_net_value(in_net_value),
    .in_fill_percent(in_fill_percent), .empty(empty), .pop(pop),
    .out_status(out_status), .out_net_result(out_net_result),
    .out_was_cleared(out_was_cleared)
  );

  always #6 clk = ~clk;

  // mirror of the map contents
  logic [chm_pkg::PtrW-1:0] head_of [chm_pkg::TableSize];
  logic [31:0] node_term [chm_pkg::NodeCount];
  logic [31:0] node_inst [chm_pkg::NodeCount];
  logic [31:0] node_net [chm_pkg::NodeCount];
  logic [chm_pkg::PtrW-1:0] node_next [chm_pkg::NodeCount];
  int unsigned nodes_taken;

  chm_pkg::result_t map_replies [$];
  int failures = 0;
  int send_gap_max = 15;
  int recv_gap_max = 15;
  int recv_hold = 0;

  logic [31:0] pool_term [48];
  logic [31:0] pool_inst [48];

  function automatic logic [chm_pkg::BktW-1:0] bucket_index(logic [31:0] term,
                                                            logic [31:0] inst);
    logic [63:0] h;
    h = {32'd0, inst} + ({32'd0, term} << chm_pkg::HashShift) + {32'd0, term};
    return chm_pkg::BktW'(h % 64'(chm_pkg::TableSize));
  endfunction

  function automatic chm_pkg::result_t hash_map_answer(chm_pkg::item_t it);
    chm_pkg::result_t r;
    logic [chm_pkg::BktW-1:0] b;
    logic [chm_pkg::PtrW-1:0] p;
    logic [chm_pkg::NodeW-1:0] id;
    int unsigned steps;
    r = '0;
    b = bucket_index(it.terminal_id, it.instance_id);
    case (it.command)
      chm_pkg::CmdInsert: begin
        if (nodes_taken >= chm_pkg::NodeCount) begin
          r.status = chm_pkg::StPoolFull;
        end else begin
          id = chm_pkg::NodeW'(nodes_taken);
          node_term[id] = it.terminal_id;
          node_inst[id] = it.instance_id;
          node_net[id] = it.net_value;
          node_next[id] = head_of[b];
          head_of[b] = chm_pkg::PtrW'(nodes_taken + 1);
          nodes_taken++;
        end
      end
      chm_pkg::CmdLookup: begin
        p = head_of[b];
        steps = 0;
        r.status = chm_pkg::StNotFound;
        while (p != '0 && int'(p) <= chm_pkg::NodeCount && steps < chm_pkg::NodeCount) begin
          id = chm_pkg::NodeW'(p - 1'b1);
          if (node_term[id] == it.terminal_id && node_inst[id] == it.instance_id) begin
            r.status = chm_pkg::StOk;
            r.net_result = node_net[id];
            break;
          end
          p = node_next[id];
          steps++;
        end
      end
      chm_pkg::CmdCleanup: begin
        if (it.fill_percent > chm_pkg::PercentFull) begin
          r.status = chm_pkg::StBadPercent;
        end else if (longint'(nodes_taken) * chm_pkg::PercentFull >=
                     longint'(it.fill_percent) * chm_pkg::TableSize) begin
          foreach (head_of[i]) head_of[i] = '0;
          nodes_taken = 0;
          r.was_cleared = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_word(chm_pkg::item_t it);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_command <= it.command;
    in_terminal_id <= it.terminal_id;
    in_instance_id <= it.instance_id;
    in_net_value <= it.net_value;
    in_fill_percent <= it.fill_percent;
    @(posedge clk);
    while (full) @(posedge clk);
    map_replies.push_back(hash_map_answer(it));
  endtask

  function automatic chm_pkg::item_t make_word(logic [1:0] c, logic [31:0] t,
                                              logic [31:0] i, logic [31:0] n,
                                              logic [6:0] f);
    chm_pkg::item_t it;
    it.command = c;
    it.terminal_id = t;
    it.instance_id = i;
    it.net_value = n;
    it.fill_percent = f;
    return it;
  endfunction

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (map_replies.size() != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
  endtask

  task automatic test_directed();
    send_word(make_word(chm_pkg::CmdLookup, 32'd5, 32'd7, $urandom, 7'd0));
    send_word(make_word(chm_pkg::CmdInsert, '0, '0, '0, 7'd127));
    send_word(make_word(chm_pkg::CmdInsert, '1, '1, '1, 7'd0));
    send_word(make_word(chm_pkg::CmdInsert, 32'd5, 32'd7, 32'h1111_2222, 7'($urandom)));
    send_word(make_word(chm_pkg::CmdInsert, 32'd5, 32'd7, 32'h3333_4444, 7'($urandom)));
    send_word(make_word(chm_pkg::CmdInsert, 32'd5, 32'd7 + chm_pkg::TableSize, 32'h5555,
                        7'($urandom)));
    send_word(make_word(chm_pkg::CmdLookup, '0, '0, $urandom, 7'($urandom)));
    send_word(make_word(chm_pkg::CmdLookup, '1, '1, $urandom, 7'($urandom)));
    send_word(make_word(chm_pkg::CmdLookup, 32'd5, 32'd7, $urandom, 7'($urandom)));
    send_word(make_word(chm_pkg::CmdLookup, 32'd5, 32'd7 + chm_pkg::TableSize, $urandom,
                        7'($urandom)));
    send_word(make_word(chm_pkg::CmdLookup, 32'd5, 32'd7 + 2 * chm_pkg::TableSize,
                        $urandom, 7'($urandom)));
    send_word(make_word(chm_pkg::CmdLookup, '1, '0, $urandom, 7'($urandom)));
    send_word(make_word(chm_pkg::CmdUnused, $urandom, $urandom, $urandom, 7'($urandom)));
    send_word(make_word(chm_pkg::CmdCleanup, $urandom, $urandom, $urandom, 7'd101));
    send_word(make_word(chm_pkg::CmdCleanup, $urandom, $urandom, $urandom, 7'd127));
    send_word(make_word(chm_pkg::CmdCleanup, $urandom, $urandom, $urandom, 7'd100));
    send_word(make_word(chm_pkg::CmdCleanup, '1, '1, '1, 7'd0));
    send_word(make_word(chm_pkg::CmdLookup, 32'd5, 32'd7, $urandom, 7'($urandom)));
    send_word(make_word(chm_pkg::CmdCleanup, '0, '0, '0, 7'd0));
    wait_drained();
  endtask

  task automatic test_pool_full();
    send_gap_max = 0;
    recv_gap_max = 0;
    for (int k = 0; k < chm_pkg::NodeCount + 3; k++)
      send_word(make_word(chm_pkg::CmdInsert, $urandom, $urandom, $urandom, 7'($urandom)));
    for (int k = 0; k < 6; k++)
      send_word(make_word(chm_pkg::CmdLookup, $urandom, $urandom, $urandom, 7'($urandom)));
    send_word(make_word(chm_pkg::CmdCleanup, $urandom, $urandom, $urandom, 7'd100));
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_gap_max = 0;
    recv_hold = 500;
    for (int k = 0; k < 80; k++)
      send_word(make_word(k % 3 == 0 ? chm_pkg::CmdLookup : chm_pkg::CmdInsert,
                          pool_term[k % 48], pool_inst[k % 48], $urandom, 7'($urandom)));
    wait_drained();
  endtask

  task automatic test_random();
    chm_pkg::item_t it;
    int r, k;
    for (int n = 0; n < 1800; n++) begin
      if (n % 150 == 0) begin
        case ($urandom_range(0, 2))
          0: send_gap_max = 0;
          1: send_gap_max = 3;
          default: send_gap_max = 15;
        endcase
        recv_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 15;
      end
      k = $urandom_range(0, 47);
      it = make_word(chm_pkg::CmdInsert, pool_term[k], pool_inst[k], $urandom,
                     7'($urandom));
      if ($urandom_range(0, 9) == 0) begin
        it.terminal_id = $urandom;
        it.instance_id = $urandom;
      end
      r = $urandom_range(0, 99);
      if (r < 45) it.command = chm_pkg::CmdInsert;
      else if (r < 87) it.command = chm_pkg::CmdLookup;
      else if (r < 96) begin
        it.command = chm_pkg::CmdCleanup;
        it.fill_percent = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(101, 127))
                                                      : 7'($urandom_range(0, 30));
      end else it.command = chm_pkg::CmdUnused;
      send_word(it);
    end
    wait_drained();
  endtask

  initial begin
    foreach (head_of[i]) head_of[i] = '0;
    nodes_taken = 0;
    for (int k = 0; k < 48; k++) begin
      pool_term[k] = $urandom;
      pool_inst[k] = $urandom;
    end
    pool_term[0] = '1;
    pool_inst[1] = '1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_pool_full();
    test_backpressure();
    test_random();
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : result_check
    chm_pkg::result_t want;
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      gap = $urandom_range(0, recv_gap_max);
      if (recv_hold > 0) begin
        gap = recv_hold;
        recv_hold = 0;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      if (map_replies.size() == 0) begin
        $error("result word with nothing expected");
        failures++;
      end else begin
        want = map_replies.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          failures++;
        end
        if (out_net_result !== want.net_result) begin
          $error("net_result: expected %h, got %h", want.net_result, out_net_result);
          failures++;
        end
        if (out_was_cleared !== want.was_cleared) begin
          $error("was_cleared: expected %0d, got %0d", want.was_cleared, out_was_cleared);
          failures++;
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end
endmodule

### sim.f
rtl/chm_pkg.sv
rtl/chm_front.sv
rtl/chm_back.sv
rtl/chained_hash_map.sv
tb/testbench.sv
